>>> rtl/lga_pkg.sv
// Shared types, constants and helper functions of the LED gradient animator.
`timescale 1ns / 1ps

package lga_pkg;

	// Phase and brightness scaling are fixed by the field widths of the block.
	localparam int PHASE_STEPS = 65536;
	localparam int PHASE_W     = $clog2(2 * PHASE_STEPS);
	localparam int FOLD_W      = $clog2(PHASE_STEPS + 1);
	localparam int PS_LOG      = $clog2(PHASE_STEPS);
	localparam int BRIGHT_BITS = 12;

	// Defaults for the top-level parameters.
	localparam int LED_NUM_DEF     = 32;
	localparam int TABLE_DEPTH_DEF = 256;

	// Field widths of the stream payloads and the configuration port.
	localparam int IDX_W    = 8;
	localparam int CH_W     = 8;
	localparam int BRI_W    = 13;
	localparam int POS_W    = 5;
	localparam int INC_W    = 16;
	localparam int CFG_IDX_W = 1;
	localparam logic [INC_W-1:0] INC_RESET = INC_W'(16);

	// The reciprocal divider produces the quotient first and then the remainder from it.
	localparam int DIV_ITERS = 2;
	localparam int DIV_CNT_W = $clog2(DIV_ITERS);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BOTTOM_INC = 1'b0,
		CFG_TOP_INC    = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		CMD_FRAME = 1'b0,
		CMD_WRITE = 1'b1
	} cmd_code_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_FIX,
		ST_RUN
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic phase_upd;
		logic tab_wr;
		logic prep;
		logic div_step;
		logic fix;
		logic emit;
	} dp_cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic adv;
		logic pipe_busy;
		logic last_led;
	} dp_sts_t;

	// Physical chain position of each logical LED.
	localparam int ORDER_LEN = 32;
	localparam logic [POS_W-1:0] LED_ORDER [ORDER_LEN] = '{
		5'd19, 5'd27, 5'd21, 5'd13, 5'd0,  5'd4,  5'd24, 5'd8,
		5'd12, 5'd15, 5'd6,  5'd5,  5'd28, 5'd29, 5'd17, 5'd3,
		5'd18, 5'd26, 5'd22, 5'd10, 5'd16, 5'd20, 5'd30, 5'd1,
		5'd25, 5'd2,  5'd14, 5'd31, 5'd7,  5'd11, 5'd9,  5'd23
	};

	// LEDs past the order list take the low POS_W bits of their own index.
	function automatic logic [POS_W-1:0] led_pos(input int unsigned i);
		logic [POS_W-1:0] p;
		if (i < ORDER_LEN) begin
			p = LED_ORDER[i[4:0]];
		end else begin
			p = i[POS_W-1:0];
		end
		return p;
	endfunction

endpackage

>>> rtl/lga_ctrl.sv
// Frame sequencer of the LED gradient animator.
`timescale 1ns / 1ps

module lga_ctrl
	import lga_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  cmd_code_t in_cmd,
	output logic      in_ready,
	input  dp_sts_t   sts,
	output dp_cmd_t   cmd
);

	ctrl_state_t            state_q, state_nxt;
	logic [DIV_CNT_W-1:0]   div_cnt_q;
	logic                   accept;

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_PREP) begin
				div_cnt_q <= '0;
			end else if (state_q == ST_DIV) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && in_cmd == CMD_FRAME) begin
					state_nxt = ST_PREP;
				end
			end
			ST_PREP: begin
				state_nxt = ST_DIV;
			end
			ST_DIV: begin
				if (div_cnt_q == DIV_CNT_W'(DIV_ITERS - 1)) begin
					state_nxt = ST_FIX;
				end
			end
			ST_FIX: begin
				state_nxt = ST_RUN;
			end
			ST_RUN: begin
				if (sts.adv && sts.last_led) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		// A table write must not overtake a read still waiting in the pipeline.
		in_ready     = (state_q == ST_IDLE) && !sts.pipe_busy;
		cmd          = '0;
		cmd.phase_upd = accept && (in_cmd == CMD_FRAME);
		cmd.tab_wr   = accept && (in_cmd == CMD_WRITE);
		cmd.prep     = (state_q == ST_PREP);
		cmd.div_step = (state_q == ST_DIV);
		cmd.fix      = (state_q == ST_FIX);
		cmd.emit     = (state_q == ST_RUN) && sts.adv;
	end

endmodule

>>> rtl/lga_datapath.sv
// Phase accumulators, gradient stepper, colour table and scaling pipeline.
`timescale 1ns / 1ps

module lga_datapath
	import lga_pkg::*;
#(
	parameter int LED_NUM     = LED_NUM_DEF,
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dp_cmd_t          cmd,
	output dp_sts_t          sts,
	input  logic [INC_W-1:0] bottom_inc,
	input  logic [INC_W-1:0] top_inc,
	input  logic [IDX_W-1:0] table_index,
	input  logic [CH_W-1:0]  table_red,
	input  logic [CH_W-1:0]  table_green,
	input  logic [CH_W-1:0]  table_blue,
	input  logic [BRI_W-1:0] brightness,
	input  logic             out_ready,
	output logic             out_valid,
	output logic [POS_W-1:0] out_pos,
	output logic [CH_W-1:0]  out_red,
	output logic [CH_W-1:0]  out_green,
	output logic [CH_W-1:0]  out_blue,
	output logic             out_last
);

	localparam int TAB_W  = $clog2(TABLE_DEPTH);
	localparam int LED_W  = $clog2(LED_NUM);
	localparam int DR_W   = $clog2(LED_NUM);
	localparam int STEP_W = FOLD_W + 2;
	localparam int PROD_W = FOLD_W + TAB_W;
	localparam int SCL_W  = CH_W + BRI_W;
	localparam int RCP_SH = FOLD_W + DR_W;
	localparam int RCP_W  = RCP_SH + 1;
	localparam int RPR_W  = FOLD_W + RCP_W;
	localparam logic [PHASE_W:0] TWO_PS  = (PHASE_W + 1)'(2 * PHASE_STEPS);
	localparam logic [DR_W:0]    DIVISOR = (DR_W + 1)'(LED_NUM - 1);
	localparam logic [RCP_W-1:0] RECIP   =
		RCP_W'(((1 << RCP_SH) + LED_NUM - 2) / (LED_NUM - 1));

	function automatic logic [FOLD_W-1:0] fold(input logic [PHASE_W-1:0] p);
		logic [PHASE_W:0] diff;
		diff = TWO_PS - {1'b0, p};
		if (p >= PHASE_W'(PHASE_STEPS)) begin
			return diff[FOLD_W-1:0];
		end
		return FOLD_W'(p);
	endfunction

	function automatic logic [CH_W-1:0] scale(input logic [CH_W-1:0] c,
			input logic [BRI_W-1:0] b);
		logic [SCL_W-1:0] prod;
		logic [SCL_W-1:0] v;
		prod = SCL_W'(c) * SCL_W'(b);
		v = prod >> BRIGHT_BITS;
		if (v > SCL_W'(255)) begin
			return '1;
		end
		return v[CH_W-1:0];
	endfunction

	// Frame state.
	logic [PHASE_W-1:0]      bot_phase_q, top_phase_q;
	logic [BRI_W-1:0]        bright_q;
	logic [FOLD_W-1:0]       fb_q;
	logic                    neg_q;
	logic [FOLD_W-1:0]       dvd_q;
	logic [FOLD_W-1:0]       quo_q;
	logic [DR_W-1:0]         drem_q;
	logic signed [STEP_W-1:0] qd_q, step_q;
	logic [DR_W-1:0]         rd_q, frac_q;
	logic [LED_W-1:0]        led_q;

	// Table read pipeline.
	logic [CH_W*3-1:0]       table_mem_q [TABLE_DEPTH];
	logic                    vld_s1, vld_s2;
	logic [TAB_W-1:0]        addr_s1;
	logic [POS_W-1:0]        pos_s1, pos_s2;
	logic                    last_s1, last_s2;
	logic [CH_W*3-1:0]       rdata_s2;
	logic                    out_valid_q, out_last_q;
	logic [POS_W-1:0]        out_pos_q;
	logic [CH_W-1:0]         out_red_q, out_green_q, out_blue_q;

	logic                    adv;
	logic [PHASE_W:0]        bot_sum, top_sum;
	logic [FOLD_W-1:0]       fb, ft;
	logic signed [FOLD_W:0]  diff;
	logic [FOLD_W:0]         diff_abs;
	logic [RPR_W-1:0]        rcp_prod;
	logic [FOLD_W-1:0]       quo_nxt;
	logic [FOLD_W-1:0]       rem_full;
	logic [DR_W:0]           frac_sum;
	logic                    carry;
	logic [DR_W-1:0]         frac_nxt;
	logic [PROD_W-1:0]       prod, idx_raw;
	logic [TAB_W-1:0]        addr_nxt;
	logic                    wr_ok;

	assign adv = !out_valid_q || out_ready;

	// The pipe stays busy until the last colour has been scaled, so that a new
	// frame cannot change the brightness and a write cannot change a pending read.
	assign sts.adv       = adv;
	assign sts.pipe_busy = vld_s1 || vld_s2;
	assign sts.last_led  = (led_q == LED_W'(LED_NUM - 1));

	always_comb begin
		bot_sum = {1'b0, bot_phase_q} + (PHASE_W + 1)'(bottom_inc);
		top_sum = {1'b0, top_phase_q} + (PHASE_W + 1)'(top_inc);
		if (bot_sum >= TWO_PS) begin
			bot_sum = bot_sum - TWO_PS;
		end
		if (top_sum >= TWO_PS) begin
			top_sum = top_sum - TWO_PS;
		end
	end

	assign fb       = fold(bot_phase_q);
	assign ft       = fold(top_phase_q);
	assign diff     = $signed({1'b0, ft}) - $signed({1'b0, fb});
	assign diff_abs = diff[FOLD_W] ? (FOLD_W + 1)'(0) - diff : diff;

	// Division of the phase difference by LED_NUM - 1 through its reciprocal.
	// The remainder is taken from the quotient of the previous step, so two
	// steps give both.
	assign rcp_prod = RPR_W'(dvd_q) * RPR_W'(RECIP);
	assign quo_nxt  = rcp_prod[RCP_SH +: FOLD_W];
	assign rem_full = dvd_q - FOLD_W'(quo_q * FOLD_W'(LED_NUM - 1));

	// The fractional part of the gradient advances by rd_q each LED.
	always_comb begin
		frac_sum = {1'b0, frac_q} + {1'b0, rd_q};
		carry    = (frac_sum >= DIVISOR);
		if (carry) begin
			frac_sum = frac_sum - DIVISOR;
		end
		frac_nxt = frac_sum[DR_W-1:0];
	end

	always_comb begin
		prod    = PROD_W'(step_q[FOLD_W-1:0]) * PROD_W'(TABLE_DEPTH);
		idx_raw = prod >> PS_LOG;
		if (idx_raw > PROD_W'(TABLE_DEPTH - 1)) begin
			addr_nxt = TAB_W'(TABLE_DEPTH - 1);
		end else begin
			addr_nxt = idx_raw[TAB_W-1:0];
		end
	end

	assign wr_ok = (32'(table_index) < 32'(TABLE_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bot_phase_q <= '0;
			top_phase_q <= '0;
			led_q       <= '0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.phase_upd) begin
				bot_phase_q <= bot_sum[PHASE_W-1:0];
				top_phase_q <= top_sum[PHASE_W-1:0];
			end
			if (cmd.fix) begin
				led_q <= '0;
			end else if (cmd.emit) begin
				led_q <= led_q + 1'b1;
			end
			if (adv) begin
				vld_s1      <= cmd.emit;
				vld_s2      <= vld_s1;
				out_valid_q <= vld_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.phase_upd) begin
			bright_q <= brightness;
		end
		if (cmd.prep) begin
			fb_q   <= fb;
			neg_q  <= diff[FOLD_W];
			dvd_q  <= diff_abs[FOLD_W-1:0];
			drem_q <= '0;
		end
		if (cmd.div_step) begin
			quo_q  <= quo_nxt;
			drem_q <= rem_full[DR_W-1:0];
		end
		if (cmd.fix) begin
			step_q <= $signed({2'b00, fb_q});
			frac_q <= '0;
			if (!neg_q) begin
				qd_q <= $signed({2'b00, quo_q});
				rd_q <= drem_q;
			end else if (drem_q == '0) begin
				qd_q <= -$signed({2'b00, quo_q});
				rd_q <= '0;
			end else begin
				qd_q <= -$signed({2'b00, quo_q}) - STEP_W'(1);
				rd_q <= DR_W'(DIVISOR - {1'b0, drem_q});
			end
		end else if (cmd.emit) begin
			step_q <= step_q + qd_q + $signed({{(STEP_W - 1){1'b0}}, carry});
			frac_q <= frac_nxt;
		end
		if (cmd.emit) begin
			addr_s1 <= addr_nxt;
			pos_s1  <= led_pos(int'(led_q));
			last_s1 <= sts.last_led;
		end
		if (adv) begin
			pos_s2  <= pos_s1;
			last_s2 <= last_s1;
			out_pos_q   <= pos_s2;
			out_last_q  <= last_s2;
			out_red_q   <= scale(rdata_s2[CH_W*3-1:CH_W*2], bright_q);
			out_green_q <= scale(rdata_s2[CH_W*2-1:CH_W], bright_q);
			out_blue_q  <= scale(rdata_s2[CH_W-1:0], bright_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tab_wr && wr_ok) begin
			table_mem_q[TAB_W'(table_index)] <= {table_red, table_green, table_blue};
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s1) begin
			rdata_s2 <= table_mem_q[addr_s1];
		end
	end

	assign out_valid = out_valid_q;
	assign out_pos   = out_pos_q;
	assign out_red   = out_red_q;
	assign out_green = out_green_q;
	assign out_blue  = out_blue_q;
	assign out_last  = out_last_q;

endmodule

>>> rtl/led_gradient_animator_unit.sv
// Top level of the LED gradient animator: stream ports, configuration and checks.
`timescale 1ns / 1ps

// A request on the input stream is either a frame tick or a colour-table write.
// A table write produces no output. A frame tick advances the bottom and top
// phase accumulators, folds both into a triangle wave, and then sends one
// colour per LED (LED_NUM requests), each tagged with the LED's physical chain
// position, with tlast on the final one. A frame occupies the block, and no
// further request is taken, while it updates the phases, folds them, runs the
// reciprocal divider that splits the top-to-bottom difference into a per-LED
// step (quotient, then remainder), sets up the stepper, issues one LED per
// cycle through the single table read port while the output does not stall,
// and lets the last table read and its scaling leave the pipeline. Each colour
// passes the table address, table read and scaled output registers, and
// backpressure on the output stalls the whole pipeline. The colour table must
// be written before an entry is used; unwritten entries read as unknown data.
// Increments should be written only while no frame is in flight.

module led_gradient_animator_unit
	import lga_pkg::*;
#(
	parameter int LED_NUM     = LED_NUM_DEF,
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// table_index[7:0], table_red[15:8], table_green[23:16], table_blue[31:24],
	// brightness[44:32], zero padding[47:45]
	input  logic [47:0]          s_axis_tdata,
	// cmd[0]
	input  logic                 s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// led_position[4:0], red[12:5], green[20:13], blue[28:21], zero padding[31:29]
	output logic [31:0]          m_axis_tdata,
	output logic                 m_axis_tlast,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [INC_W-1:0]     cfg_wdata
);

	logic [INC_W-1:0] bottom_inc_q, top_inc_q;
	dp_cmd_t          cmd;
	dp_sts_t          sts;
	logic [POS_W-1:0] out_pos;
	logic [CH_W-1:0]  out_red, out_green, out_blue;

	// Increment registers; both indexes of the port are in use.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bottom_inc_q <= INC_RESET;
			top_inc_q    <= INC_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_BOTTOM_INC: bottom_inc_q <= cfg_wdata;
				CFG_TOP_INC:    top_inc_q    <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	lga_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_cmd   (cmd_code_t'(s_axis_tuser)),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lga_datapath #(
		.LED_NUM     (LED_NUM),
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.bottom_inc  (bottom_inc_q),
		.top_inc     (top_inc_q),
		.table_index (s_axis_tdata[7:0]),
		.table_red   (s_axis_tdata[15:8]),
		.table_green (s_axis_tdata[23:16]),
		.table_blue  (s_axis_tdata[31:24]),
		.brightness  (s_axis_tdata[44:32]),
		.out_ready   (m_axis_tready),
		.out_valid   (m_axis_tvalid),
		.out_pos     (out_pos),
		.out_red     (out_red),
		.out_green   (out_green),
		.out_blue    (out_blue),
		.out_last    (m_axis_tlast)
	);

	assign m_axis_tdata = {3'b000, out_blue, out_green, out_red, out_pos};

	// A frame tick keeps the input closed for the following cycle.
	a_frame_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_FRAME)
		|=> !s_axis_tready)
		else $error("input taken right after a frame tick");

	// No request, and so no table write, is taken while a table read is pending.
	a_no_write_over_read: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |-> !sts.pipe_busy)
		else $error("request taken with a table read pending");

	// Nothing follows the last colour of a frame in the next cycle.
	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
		else $error("output valid right after the last colour of a frame");

endmodule

>>> sim/lga_checker.sv
// Checker for the LED gradient animator: predicts each frame and compares the output stream.
`timescale 1ns / 1ps

module lga_checker
	import lga_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	input  logic                 s_axis_tready,
	input  logic [47:0]          s_axis_tdata,
	input  logic                 s_axis_tuser,
	input  logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	input  logic [31:0]          m_axis_tdata,
	input  logic                 m_axis_tlast,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [INC_W-1:0]     cfg_wdata,
	output int unsigned          mismatches,
	output int unsigned          colours_pending,
	output int unsigned          colours_seen
);

	localparam int LEDS       = 32;
	localparam int ENTRIES    = 256;
	localparam int PHASE_MOD  = 2 * PHASE_STEPS;
	localparam int REPORT_MAX = 10;

	// Physical chain position of each logical LED.
	localparam logic [4:0] CHAIN_POS [LEDS] = '{
		5'd19, 5'd27, 5'd21, 5'd13, 5'd0,  5'd4,  5'd24, 5'd8,
		5'd12, 5'd15, 5'd6,  5'd5,  5'd28, 5'd29, 5'd17, 5'd3,
		5'd18, 5'd26, 5'd22, 5'd10, 5'd16, 5'd20, 5'd30, 5'd1,
		5'd25, 5'd2,  5'd14, 5'd31, 5'd7,  5'd11, 5'd9,  5'd23
	};

	typedef struct packed {
		logic [4:0] pos;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} led_pixel_t;

	led_pixel_t expected_colours [$];
	logic [23:0] palette [ENTRIES];
	logic [16:0] bottom_ph;
	logic [16:0] top_ph;
	logic [15:0] bottom_inc;
	logic [15:0] top_inc;

	function automatic logic [16:0] advance(input logic [16:0] ph, input logic [15:0] inc);
		logic [17:0] sum;
		sum = 18'(ph) + 18'(inc);
		if (sum >= 18'(PHASE_MOD)) begin
			sum = sum - 18'(PHASE_MOD);
		end
		return sum[16:0];
	endfunction

	// Triangle wave: phases in the upper half walk back down to zero.
	function automatic logic [16:0] fold_phase(input logic [16:0] ph);
		logic [17:0] back;
		back = 18'(PHASE_MOD) - 18'(ph);
		return (ph >= 17'(PHASE_STEPS)) ? back[16:0] : ph;
	endfunction

	// Channel times brightness, full scale at 2^BRIGHT_BITS, clipped at 255.
	function automatic logic [7:0] dim(input logic [7:0] c, input logic [12:0] b);
		logic [20:0] prod;
		prod = (21'(c) * 21'(b)) >> BRIGHT_BITS;
		return (prod > 21'd255) ? 8'hFF : prod[7:0];
	endfunction

	task automatic predict_frame(input logic [12:0] bright);
		logic [16:0] fb;
		logic [16:0] ft;
		int unsigned mix;
		int unsigned slot;
		logic [23:0] rgb;
		led_pixel_t c;
		int i;
		bottom_ph = advance(bottom_ph, bottom_inc);
		top_ph = advance(top_ph, top_inc);
		fb = fold_phase(bottom_ph);
		ft = fold_phase(top_ph);
		for (i = 0; i < LEDS; i++) begin
			mix = (32'(LEDS - 1 - i) * 32'(fb) + 32'(i) * 32'(ft)) / 32'(LEDS - 1);
			slot = mix * ENTRIES / PHASE_STEPS;
			// At the fold peak the step would point one entry past the table.
			if (slot > ENTRIES - 1) begin
				slot = ENTRIES - 1;
			end
			rgb = palette[slot];
			c.pos = CHAIN_POS[i];
			c.red = dim(rgb[23:16], bright);
			c.green = dim(rgb[15:8], bright);
			c.blue = dim(rgb[7:0], bright);
			c.last = (i == LEDS - 1);
			expected_colours.push_back(c);
		end
	endtask

	task automatic note_failure(input string msg);
		mismatches++;
		if (mismatches <= REPORT_MAX) begin
			$display("%0t ns: %s", $realtime, msg);
		end
	endtask

	task automatic check_colour();
		led_pixel_t got;
		led_pixel_t want;
		got.pos = m_axis_tdata[4:0];
		got.red = m_axis_tdata[12:5];
		got.green = m_axis_tdata[20:13];
		got.blue = m_axis_tdata[28:21];
		got.last = m_axis_tlast;
		colours_seen++;
		if (expected_colours.size() == 0) begin
			note_failure($sformatf("unexpected colour: pos %0d rgb %h %h %h last %b",
				got.pos, got.red, got.green, got.blue, got.last));
		end else begin
			want = expected_colours.pop_front();
			colours_pending = expected_colours.size();
			if (got.pos !== want.pos || got.red !== want.red || got.green !== want.green
					|| got.blue !== want.blue || got.last !== want.last) begin
				note_failure($sformatf({"colour mismatch: expected pos %0d rgb %h %h %h",
					" last %b, got pos %0d rgb %h %h %h last %b"},
					want.pos, want.red, want.green, want.blue, want.last,
					got.pos, got.red, got.green, got.blue, got.last));
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bottom_ph = '0;
			top_ph = '0;
			bottom_inc = INC_RESET;
			top_inc = INC_RESET;
			expected_colours.delete();
			mismatches = 0;
			colours_pending = 0;
			colours_seen = 0;
		end else begin
			// Outputs first: a request accepted at the same edge cannot own them.
			if (m_axis_tvalid && m_axis_tready) begin
				check_colour();
			end
			if (cfg_we) begin
				if (cfg_reg_t'(cfg_index) == CFG_BOTTOM_INC) begin
					bottom_inc = cfg_wdata;
				end else begin
					top_inc = cfg_wdata;
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (cmd_code_t'(s_axis_tuser) == CMD_WRITE) begin
					palette[s_axis_tdata[7:0]] = s_axis_tdata[31:8] == s_axis_tdata[31:8]
						? {s_axis_tdata[15:8], s_axis_tdata[23:16], s_axis_tdata[31:24]}
						: 24'hx;
				end else begin
					predict_frame(s_axis_tdata[44:32]);
					colours_pending = expected_colours.size();
				end
			end
		end
	end

endmodule

>>> sim/tb_top.sv
// Testbench top for the LED gradient animator: stimulus, output pacing, watchdog and verdict.
`timescale 1ns / 1ps

// The run starts by loading every colour-table entry, so that no frame can
// ever read an entry that was never written. A short directed part follows:
// frames at the reset increments, brightness at zero, full scale and beyond,
// a bottom phase that lands exactly on the fold peak, writes to the first and
// last entries with all-zero and all-one colours, and zero increments that
// freeze both phases. Then several random segments run, each with its own
// pair of increments (both extremes among them), mixing frame ticks with
// table writes. Increments are only changed after every expected colour has
// arrived and the block has settled. The lga_checker instance
// predicts and compares; this module only drives requests and gives the verdict.

module tb_top;
	import lga_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE      = 8;
	localparam int SEGMENTS    = 6;
	localparam int SEG_ITEMS   = 4;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [47:0]          s_axis_tdata;
	logic                 s_axis_tuser;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [31:0]          m_axis_tdata;
	logic                 m_axis_tlast;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [INC_W-1:0]     cfg_wdata;

	int unsigned mismatches;
	int unsigned colours_pending;
	int unsigned colours_seen;

	// Statistics for the closing summary, and the switch for input gaps.
	int unsigned frames_sent;
	int unsigned writes_sent;
	int unsigned settings_used;
	bit          gaps_on;

	led_gradient_animator_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	lga_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tuser    (s_axis_tuser),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tlast    (m_axis_tlast),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.mismatches      (mismatches),
		.colours_pending (colours_pending),
		.colours_seen    (colours_seen)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Most gaps are empty or short; now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (!gaps_on || r < 55) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 96) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] pick_colour();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Mostly in range, with a share above full scale to exercise saturation.
	function automatic logic [12:0] pick_brightness();
		case ($urandom_range(0, 7))
			0: return 13'd0;
			1: return 13'd4096;
			2: return 13'd8191;
			3: return 13'($urandom_range(4097, 8191));
			default: return 13'($urandom_range(0, 4096));
		endcase
	endfunction

	function automatic logic [15:0] pick_increment();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'h8000;
			3: return 16'($urandom_range(1, 64));
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// Offers one request after a random gap and holds it until it is taken.
	task automatic push_request(input cmd_code_t cmd, input logic [7:0] idx,
			input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
			input logic [12:0] bright);
		int unsigned gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {3'b000, bright, b, g, r, idx};
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		if (cmd == CMD_FRAME) begin
			frames_sent++;
		end else begin
			writes_sent++;
		end
	endtask

	task automatic push_frame(input logic [12:0] bright);
		push_request(CMD_FRAME, 8'($urandom_range(0, 255)), pick_colour(), pick_colour(),
			pick_colour(), bright);
	endtask

	task automatic push_write(input logic [7:0] idx, input logic [23:0] rgb);
		push_request(CMD_WRITE, idx, rgb[23:16], rgb[15:8], rgb[7:0], pick_brightness());
	endtask

	// Lets the block go quiet: every expected colour in, then a settling wait.
	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (colours_pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic program_increments(input logic [15:0] bottom, input logic [15:0] top);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_BOTTOM_INC;
		cfg_wdata <= bottom;
		@(negedge clk);
		cfg_index <= CFG_TOP_INC;
		cfg_wdata <= top;
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic random_segment(input int unsigned count);
		int unsigned n;
		for (n = 0; n < count; n++) begin
			if ($urandom_range(0, 99) < 45) begin
				push_frame(pick_brightness());
			end else begin
				push_write(8'($urandom_range(0, 255)),
					{pick_colour(), pick_colour(), pick_colour()});
			end
		end
	endtask

	// Output backpressure: ready runs, short stalls, and the odd long one.
	initial begin : sink_pacing
		int unsigned hold;
		int unsigned r;
		logic rdy;
		m_axis_tready = 1'b0;
		hold = 0;
		rdy = 1'b1;
		forever begin
			@(negedge clk);
			if (hold == 0) begin
				r = $urandom_range(0, 99);
				if (r < 50) begin
					rdy = 1'b1;
					hold = $urandom_range(1, 30);
				end else if (r < 58) begin
					rdy = 1'b1;
					hold = $urandom_range(60, 200);
				end else if (r < 92) begin
					rdy = 1'b0;
					hold = $urandom_range(1, 3);
				end else begin
					rdy = 1'b0;
					hold = $urandom_range(8, 40);
				end
			end else begin
				hold--;
			end
			m_axis_tready <= rdy;
		end
	end

	// Ends the run if no request moves on either stream for too long.
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| cfg_we) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("Watchdog: nothing moved for %0d cycles, %0d colours still expected.",
			STALL_LIMIT, colours_pending);
		$display("== FAIL ==");
		$finish;
	end

	initial begin : stimulus
		int unsigned k;
		int unsigned seg;
		logic [15:0] bottom;
		logic [15:0] top;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = CMD_FRAME;
		cfg_we = 1'b0;
		cfg_index = CFG_BOTTOM_INC;
		cfg_wdata = '0;
		frames_sent = 0;
		writes_sent = 0;
		settings_used = 1;
		gaps_on = 1'b1;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// Load the whole table before any frame can read it.
		for (k = 0; k < 256; k++) begin
			push_write(8'(k), {pick_colour(), pick_colour(), pick_colour()});
		end

		// Reset increments of 16, at full scale and at zero brightness.
		push_frame(13'd4096);
		push_frame(13'd0);
		wait_drained();

		// Bottom phase sits at 32 now, so this increment lands on the fold peak.
		// The top increment pushes that phase past the peak and, next frame, wraps it.
		program_increments(16'd65504, 16'hFFFF);
		push_frame(13'd8191);
		push_write(8'd255, 24'hFFFFFF);
		push_write(8'd0, 24'h000000);
		push_frame(13'd4095);
		push_write(8'd128, {pick_colour(), pick_colour(), pick_colour()});
		push_frame(13'd1);
		push_frame(13'd4097);
		wait_drained();

		// Zero increments leave both phases where they are.
		program_increments(16'd0, 16'd0);
		push_frame(13'd2048);
		push_frame(13'd8191);
		wait_drained();

		for (seg = 0; seg < SEGMENTS; seg++) begin
			case (seg)
				0: begin
					bottom = 16'd0;
					top = 16'hFFFF;
				end
				1: begin
					bottom = 16'hFFFF;
					top = 16'd0;
				end
				default: begin
					bottom = pick_increment();
					top = pick_increment();
				end
			endcase
			gaps_on = (seg % 3 != 2);
			program_increments(bottom, top);
			random_segment(SEG_ITEMS);
			wait_drained();
		end

		$display("Covered %0d frame ticks and %0d table writes over %0d increment settings;",
			frames_sent, writes_sent, settings_used);
		$display("%0d LED colours checked, %0d failures, %0d colours never delivered.",
			colours_seen, mismatches, colours_pending);
		if (mismatches == 0 && colours_pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
